/* sv/assert_macros.svh */
// Assertion helpers used by the collision manifold back end.
// Both macros expect a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CM2_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define CM2_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* sv/cm2_pkg.sv */
// ----------------------------------------------------------------------------
// Collision manifold package
// Shared constants, pair kinds and the queue status bundle.
// ----------------------------------------------------------------------------
package cm2_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		OP_BOX_BOX       = 2'd0,
		OP_CIRCLE_CIRCLE = 2'd1,
		OP_CIRCLE_BOX    = 2'd2,
		OP_BOX_CIRCLE    = 2'd3
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* sv/collision_manifold_2d_top.sv */
// ----------------------------------------------------------------------------
// Collision manifold 2D top level
// Contact manifold for box and circle pairs in signed fixed point.
// ----------------------------------------------------------------------------
// A new pair may be started in every cycle; busy only rises if the internal
// queue fills, which does not happen in normal use as the back end never
// stalls. Each pair yields one result on done, after it has passed the front
// end register, the queue, the first and second back end stages, the pipelined
// square root (one bit per stage), the normal divider (one quotient bit per
// stage) and the output register. The receiver cannot stall, so results must be taken
// when done is high.
module collision_manifold_2d_top #(
	parameter int FRAC_BITS   = cm2_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = cm2_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic [COORD_WIDTH-2:0]        a_width,
	input  logic [COORD_WIDTH-2:0]        a_height,
	input  logic [COORD_WIDTH-3:0]        a_radius,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic [COORD_WIDTH-2:0]        b_width,
	input  logic [COORD_WIDTH-2:0]        b_height,
	input  logic [COORD_WIDTH-3:0]        b_radius,
	output logic                          done,
	output logic                          hit,
	output logic [COORD_WIDTH-1:0]        penetration,
	output logic signed [FRAC_BITS+1:0]   normal_x,
	output logic signed [FRAC_BITS+1:0]   normal_y,
	output logic                          order_swapped
);

	localparam int EW = 8 * COORD_WIDTH - 4;

	cm2_pkg::q_status_t q_status;
	logic               push;
	logic               pop;
	logic [EW-1:0]      entry;
	logic [EW-1:0]      head;

	cm2_front #(
		.CW(COORD_WIDTH),
		.EW(EW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operation(operation),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_width  (a_width),
		.a_height (a_height),
		.a_radius (a_radius),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_width  (b_width),
		.b_height (b_height),
		.b_radius (b_radius),
		.q_status (q_status),
		.push     (push),
		.entry    (entry)
	);

	cm2_queue #(
		.EW   (EW),
		.DEPTH(cm2_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (entry),
		.pop   (pop),
		.rdata (head),
		.status(q_status)
	);

	cm2_back #(
		.CW(COORD_WIDTH),
		.FB(FRAC_BITS),
		.EW(EW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.head         (head),
		.pop          (pop),
		.done         (done),
		.hit          (hit),
		.penetration  (penetration),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.order_swapped(order_swapped)
	);

endmodule

/* sv/cm2_front.sv */
// ----------------------------------------------------------------------------
// Collision manifold front end
// Accepts a pair, classifies it and forms the offsets and box sizes.
// ----------------------------------------------------------------------------
module cm2_front #(
	parameter int CW = cm2_pkg::COORD_WIDTH_DEF,
	parameter int EW = 8 * CW - 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              operation,
	input  logic signed [CW-1:0]    a_x,
	input  logic signed [CW-1:0]    a_y,
	input  logic [CW-2:0]           a_width,
	input  logic [CW-2:0]           a_height,
	input  logic [CW-3:0]           a_radius,
	input  logic signed [CW-1:0]    b_x,
	input  logic signed [CW-1:0]    b_y,
	input  logic [CW-2:0]           b_width,
	input  logic [CW-2:0]           b_height,
	input  logic [CW-3:0]           b_radius,
	input  cm2_pkg::q_status_t      q_status,
	output logic                    push,
	output logic [EW-1:0]           entry
);

	logic                accept;
	logic                valid_s1;
	logic [EW-1:0]       entry_s1;
	logic signed [CW:0]  dx;
	logic signed [CW:0]  dy;
	logic [CW-2:0]       sxa, sya, sxb, syb;

	assign busy   = valid_s1 && q_status.full;
	assign accept = start && !busy;
	assign push   = valid_s1 && !q_status.full;
	assign entry  = entry_s1;

	always_comb begin
		if (operation == cm2_pkg::OP_BOX_CIRCLE) begin
			dx = {a_x[CW-1], a_x} - {b_x[CW-1], b_x};
			dy = {a_y[CW-1], a_y} - {b_y[CW-1], b_y};
		end else begin
			dx = {b_x[CW-1], b_x} - {a_x[CW-1], a_x};
			dy = {b_y[CW-1], b_y} - {a_y[CW-1], a_y};
		end
		case (operation)
			cm2_pkg::OP_CIRCLE_BOX: begin
				sxa = {a_radius, 1'b0};
				sya = {a_radius, 1'b0};
				sxb = b_width;
				syb = b_height;
			end
			cm2_pkg::OP_BOX_CIRCLE: begin
				sxa = {b_radius, 1'b0};
				sya = {b_radius, 1'b0};
				sxb = a_width;
				syb = a_height;
			end
			default: begin
				sxa = a_width;
				sya = a_height;
				sxb = b_width;
				syb = b_height;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= {operation, dx, dy, sxa, sya, sxb, syb, a_radius, b_radius};
		end
	end

endmodule

/* sv/cm2_queue.sv */
// ----------------------------------------------------------------------------
// Collision manifold item queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module cm2_queue #(
	parameter int EW    = 8 * cm2_pkg::COORD_WIDTH_DEF - 4,
	parameter int DEPTH = cm2_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [EW-1:0]      wdata,
	input  logic               pop,
	output logic [EW-1:0]      rdata,
	output cm2_pkg::q_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [EW-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] count_q;

	assign status.full  = (count_q == NW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rdata        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

/* sv/cm2_back.sv */
// ----------------------------------------------------------------------------
// Collision manifold back end
// Box overlap, circle squares, pipelined square root and normal division.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cm2_back #(
	parameter int CW = cm2_pkg::COORD_WIDTH_DEF,
	parameter int FB = cm2_pkg::FRAC_BITS_DEF,
	parameter int EW = 8 * CW - 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cm2_pkg::q_status_t   q_status,
	input  logic [EW-1:0]        head,
	output logic                 pop,
	output logic                 done,
	output logic                 hit,
	output logic [CW-1:0]        penetration,
	output logic signed [FB+1:0] normal_x,
	output logic signed [FB+1:0] normal_y,
	output logic                 order_swapped
);

	localparam int LAST = CW + FB + 1;
	localparam int LAT  = LAST + 3;
	localparam int SW   = 2 * CW - 1;
	localparam int TW   = 2 * CW + 1;
	localparam logic [FB+1:0] NORM_ONE = {2'b01, {FB{1'b0}}};
	localparam logic [FB+1:0] NORM_NEG = {2'b11, {FB{1'b0}}};

	// Head fields
	logic [1:0]          h_op;
	logic signed [CW:0]  h_dx, h_dy;
	logic [CW-2:0]       h_sxa, h_sya, h_sxb, h_syb;
	logic [CW-3:0]       h_ra, h_rb;

	assign pop = !q_status.empty;
	assign {h_op, h_dx, h_dy, h_sxa, h_sya, h_sxb, h_syb, h_ra, h_rb} = head;

	// First stage logic
	logic [CW:0]          ax, ay;
	logic [CW-1:0]        sumx, sumy;
	logic signed [CW+2:0] dxo, dyo, pd, pinc;
	logic                 bhit, bx_gt;
	logic [CW-2:0]        rs;
	logic [FB+1:0]        bnx, bny;

	always_comb begin
		ax    = h_dx[CW] ? (~h_dx + 1'b1) : h_dx;
		ay    = h_dy[CW] ? (~h_dy + 1'b1) : h_dy;
		sumx  = {1'b0, h_sxa} + {1'b0, h_sxb};
		sumy  = {1'b0, h_sya} + {1'b0, h_syb};
		dxo   = $signed({3'b000, sumx}) - $signed({1'b0, ax, 1'b0});
		dyo   = $signed({3'b000, sumy}) - $signed({1'b0, ay, 1'b0});
		bhit  = (dxo > 0) && (dyo > 0);
		bx_gt = dxo > dyo;
		pd    = bx_gt ? dxo : dyo;
		pinc  = pd + (CW+3)'(1);
		rs    = {1'b0, h_ra} + {1'b0, h_rb};
		bnx   = '0;
		bny   = '0;
		if (bhit && bx_gt) begin
			bnx = h_dx[CW] ? NORM_NEG : NORM_ONE;
		end else if (bhit) begin
			bny = h_dy[CW] ? NORM_NEG : NORM_ONE;
		end
	end

	logic                valid_s1, swp_s1, circ_s1, bhit_s1, sgx_s1, sgy_s1, early_s1;
	logic [CW-1:0]       bpen_s1;
	logic [FB+1:0]       bnx_s1, bny_s1;
	logic [CW-2:0]       axn_s1, ayn_s1, rs_s1;
	logic [CW-3:0]       ra_s1;
	logic [2*CW-3:0]     sqx_s1, sqy_s1, rs2_s1;

	// Second stage logic
	logic [SW-1:0]       ssum;
	assign ssum = {1'b0, sqx_s1} + {1'b0, sqy_s1};

	// Shift line that carries an item alongside the root and division steps
	logic                v_q    [0:LAST];
	logic                swp_q  [0:LAST];
	logic                circ_q [0:LAST];
	logic                bhit_q [0:LAST];
	logic [CW-1:0]       bpen_q [0:LAST];
	logic [FB+1:0]       bnx_q  [0:LAST];
	logic [FB+1:0]       bny_q  [0:LAST];
	logic                sgx_q  [0:LAST];
	logic                sgy_q  [0:LAST];
	logic [CW-2:0]       axn_q  [0:LAST];
	logic [CW-2:0]       ayn_q  [0:LAST];
	logic [CW-3:0]       ra_q   [0:LAST];
	logic [CW-2:0]       rs_q   [0:LAST];
	logic                chit_q [0:LAST];
	logic                zero_q [0:LAST];

	// Square root, one result bit per stage
	logic [CW-1:0]       c_q    [0:CW];
	logic [SW-1:0]       rem_q  [0:CW];
	logic [CW-1:0]       c_nxt  [1:CW];
	logic [SW-1:0]       rem_nxt[1:CW];

	for (genvar k = 1; k <= CW; k++) begin : g_sqrt
		localparam int I = CW - k;
		logic [TW-1:0] trial;
		logic          fits;
		assign trial      = ({{(CW+1){1'b0}}, c_q[k-1]} << (I + 1)) | (TW'(1) << (2 * I));
		assign fits       = trial <= {2'b00, rem_q[k-1]};
		assign rem_nxt[k] = fits ? (rem_q[k-1] - trial[SW-1:0]) : rem_q[k-1];
		assign c_nxt[k]   = fits ? (c_q[k-1] | (CW'(1) << I)) : c_q[k-1];
	end

	// Normal division, integer bit then one fraction bit per stage
	logic [CW-1:0]       d_q    [1:FB+1];
	logic [CW:0]         rx_q   [1:FB+1];
	logic [CW:0]         ry_q   [1:FB+1];
	logic [FB:0]         qx_q   [1:FB+1];
	logic [FB:0]         qy_q   [1:FB+1];
	logic [CW-1:0]       d_nxt  [1:FB+1];
	logic [CW:0]         rx_nxt [1:FB+1];
	logic [CW:0]         ry_nxt [1:FB+1];
	logic [FB:0]         qx_nxt [1:FB+1];
	logic [FB:0]         qy_nxt [1:FB+1];

	for (genvar j = 1; j <= FB + 1; j++) begin : g_div
		logic [CW:0]   rxi, ryi;
		logic [FB:0]   qxi, qyi;
		logic          fx, fy;
		if (j == 1) begin : g_first
			assign d_nxt[j] = c_q[CW];
			assign rxi      = {2'b00, axn_q[CW]};
			assign ryi      = {2'b00, ayn_q[CW]};
			assign qxi      = '0;
			assign qyi      = '0;
		end else begin : g_rest
			assign d_nxt[j] = d_q[j-1];
			assign rxi      = {rx_q[j-1][CW-1:0], 1'b0};
			assign ryi      = {ry_q[j-1][CW-1:0], 1'b0};
			assign qxi      = {qx_q[j-1][FB-1:0], 1'b0};
			assign qyi      = {qy_q[j-1][FB-1:0], 1'b0};
		end
		assign fx        = rxi >= {1'b0, d_nxt[j]};
		assign fy        = ryi >= {1'b0, d_nxt[j]};
		assign rx_nxt[j] = fx ? (rxi - {1'b0, d_nxt[j]}) : rxi;
		assign ry_nxt[j] = fy ? (ryi - {1'b0, d_nxt[j]}) : ryi;
		assign qx_nxt[j] = qxi | {{FB{1'b0}}, fx};
		assign qy_nxt[j] = qyi | {{FB{1'b0}}, fy};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int k = 0; k <= LAST; k++) begin
				v_q[k] <= 1'b0;
			end
		end else begin
			valid_s1 <= pop;
			v_q[0]   <= valid_s1;
			for (int k = 1; k <= LAST; k++) begin
				v_q[k] <= v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		swp_s1   <= (h_op == cm2_pkg::OP_BOX_CIRCLE);
		circ_s1  <= (h_op == cm2_pkg::OP_CIRCLE_CIRCLE);
		bhit_s1  <= bhit;
		bpen_s1  <= bhit ? pinc[CW:1] : '0;
		bnx_s1   <= bnx;
		bny_s1   <= bny;
		sgx_s1   <= h_dx[CW];
		sgy_s1   <= h_dy[CW];
		early_s1 <= (ax >= {2'b00, rs}) || (ay >= {2'b00, rs});
		axn_s1   <= ax[CW-2:0];
		ayn_s1   <= ay[CW-2:0];
		rs_s1    <= rs;
		ra_s1    <= h_ra;
		sqx_s1   <= {{(CW-1){1'b0}}, ax[CW-2:0]} * {{(CW-1){1'b0}}, ax[CW-2:0]};
		sqy_s1   <= {{(CW-1){1'b0}}, ay[CW-2:0]} * {{(CW-1){1'b0}}, ay[CW-2:0]};
		rs2_s1   <= {{(CW-1){1'b0}}, rs} * {{(CW-1){1'b0}}, rs};

		swp_q[0]  <= swp_s1;
		circ_q[0] <= circ_s1;
		bhit_q[0] <= bhit_s1;
		bpen_q[0] <= bpen_s1;
		bnx_q[0]  <= bnx_s1;
		bny_q[0]  <= bny_s1;
		sgx_q[0]  <= sgx_s1;
		sgy_q[0]  <= sgy_s1;
		axn_q[0]  <= axn_s1;
		ayn_q[0]  <= ayn_s1;
		ra_q[0]   <= ra_s1;
		rs_q[0]   <= rs_s1;
		chit_q[0] <= !early_s1 && ({1'b0, rs2_s1} > ssum);
		zero_q[0] <= (ssum == '0);
		c_q[0]    <= '0;
		rem_q[0]  <= ssum;
		for (int k = 1; k <= LAST; k++) begin
			swp_q[k]  <= swp_q[k-1];
			circ_q[k] <= circ_q[k-1];
			bhit_q[k] <= bhit_q[k-1];
			bpen_q[k] <= bpen_q[k-1];
			bnx_q[k]  <= bnx_q[k-1];
			bny_q[k]  <= bny_q[k-1];
			sgx_q[k]  <= sgx_q[k-1];
			sgy_q[k]  <= sgy_q[k-1];
			axn_q[k]  <= axn_q[k-1];
			ayn_q[k]  <= ayn_q[k-1];
			ra_q[k]   <= ra_q[k-1];
			rs_q[k]   <= rs_q[k-1];
			chit_q[k] <= chit_q[k-1];
			zero_q[k] <= zero_q[k-1];
		end
		for (int k = 1; k <= CW; k++) begin
			c_q[k]   <= c_nxt[k];
			rem_q[k] <= rem_nxt[k];
		end
		for (int j = 1; j <= FB + 1; j++) begin
			d_q[j]  <= d_nxt[j];
			rx_q[j] <= rx_nxt[j];
			ry_q[j] <= ry_nxt[j];
			qx_q[j] <= qx_nxt[j];
			qy_q[j] <= qy_nxt[j];
		end
	end

	// Result selection
	logic                r_hit;
	logic [CW-1:0]       r_pen;
	logic [FB+1:0]       r_nx, r_ny;
	logic [FB+1:0]       cqx, cqy;

	always_comb begin
		cqx = {1'b0, qx_q[FB+1]};
		cqy = {1'b0, qy_q[FB+1]};
		if (sgx_q[LAST]) begin
			cqx = ~cqx + 1'b1;
		end
		if (sgy_q[LAST]) begin
			cqy = ~cqy + 1'b1;
		end
		if (!circ_q[LAST]) begin
			r_hit = bhit_q[LAST];
			r_pen = bpen_q[LAST];
			r_nx  = bnx_q[LAST];
			r_ny  = bny_q[LAST];
		end else if (!chit_q[LAST]) begin
			r_hit = 1'b0;
			r_pen = '0;
			r_nx  = '0;
			r_ny  = '0;
		end else if (zero_q[LAST]) begin
			r_hit = 1'b1;
			r_pen = {2'b00, ra_q[LAST]};
			r_nx  = NORM_ONE;
			r_ny  = '0;
		end else begin
			r_hit = 1'b1;
			r_pen = {1'b0, rs_q[LAST]} - d_q[FB+1];
			r_nx  = cqx;
			r_ny  = cqy;
		end
	end

	logic                done_q, hit_q, swp_out_q;
	logic [CW-1:0]       pen_q;
	logic [FB+1:0]       nx_q, ny_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_q[LAST];
		end
	end

	always_ff @(posedge clk) begin
		hit_q     <= r_hit;
		pen_q     <= r_pen;
		nx_q      <= r_nx;
		ny_q      <= r_ny;
		swp_out_q <= swp_q[LAST];
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign penetration   = pen_q;
	assign normal_x      = $signed(nx_q);
	assign normal_y      = $signed(ny_q);
	assign order_swapped = swp_out_q;

	`CM2_ASSERT_IMPL(a_latency, done, $past(pop, LAT), "result strobe out of step with pop")
	`CM2_ASSERT_IMPL(a_miss_zero, done && !hit, (penetration == '0) && (nx_q == '0) && (ny_q == '0), "miss with non-zero manifold")
	`CM2_ASSERT_IMPL(a_box_axis, v_q[LAST] && !circ_q[LAST] && bhit_q[LAST], (bnx_q[LAST] == '0) != (bny_q[LAST] == '0), "box normal not on one axis")

endmodule

/* tb/tb_collision_manifold_2d_top.sv */
// ----------------------------------------------------------------------------
// Collision manifold 2D testbench
// Sends directed and random box and circle pairs to the block, takes each expected
// manifold from its table row or works it out on its own, and compares every result, field by field.
// ----------------------------------------------------------------------------
module tb_collision_manifold_2d_top;

	localparam int FB = cm2_pkg::FRAC_BITS_DEF;
	localparam int CW = cm2_pkg::COORD_WIDTH_DEF;
	localparam longint NORM_ONE = longint'(1) << FB;
	localparam longint PEN_MAX = (longint'(1) << CW) - 1;

	typedef struct {
		cm2_pkg::op_t         op;
		logic signed [CW-1:0] ax, ay, bx, by;
		logic [CW-2:0]        aw, ah, bw, bh;
		logic [CW-3:0]        ar, br;
	} pair_t;

	typedef struct {
		logic          hit;
		logic [CW-1:0] pen;
		logic [FB+1:0] nx, ny;
		logic          swapped;
	} manifold_t;

	typedef struct {
		pair_t     pair;
		bit        typed;
		manifold_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start, busy, done, hit, order_swapped;
	logic [1:0] operation;
	logic signed [CW-1:0] a_x, a_y, b_x, b_y;
	logic [CW-2:0] a_width, a_height, b_width, b_height;
	logic [CW-3:0] a_radius, b_radius;
	logic [CW-1:0] penetration;
	logic signed [FB+1:0] normal_x, normal_y;

	manifold_t pending_manifolds[$];
	int fail_count = 0;

	collision_manifold_2d_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .a_x(a_x), .a_y(a_y), .a_width(a_width),
		.a_height(a_height), .a_radius(a_radius), .b_x(b_x), .b_y(b_y),
		.b_width(b_width), .b_height(b_height), .b_radius(b_radius),
		.done(done), .hit(hit), .penetration(penetration), .normal_x(normal_x),
		.normal_y(normal_y), .order_swapped(order_swapped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic void box_overlap(input longint ox, input longint oy,
			input longint sxa, input longint sya, input longint sxb,
			input longint syb, inout manifold_t m);
		longint dxo, dyo, p;
		dxo = sxa + sxb - 2 * magnitude(ox);
		dyo = sya + syb - 2 * magnitude(oy);
		if (dxo <= 0 || dyo <= 0)
			return;
		m.hit = 1'b1;
		if (dxo > dyo) begin
			p = (dxo + 1) >>> 1;
			m.nx = (FB+2)'(ox < 0 ? -NORM_ONE : NORM_ONE);
		end else begin
			p = (dyo + 1) >>> 1;
			m.ny = (FB+2)'(oy < 0 ? -NORM_ONE : NORM_ONE);
		end
		m.pen = CW'(p > PEN_MAX ? PEN_MAX : p);
	endfunction

	function automatic void circle_overlap(input longint dx, input longint dy,
			input longint ra, input longint rb, inout manifold_t m);
		longint rs, qx, qy;
		longint unsigned s, c, t;
		rs = ra + rb;
		if (magnitude(dx) >= rs || magnitude(dy) >= rs)
			return;
		s = dx * dx + dy * dy;
		if (rs * rs <= s)
			return;
		m.hit = 1'b1;
		if (s == 0) begin
			m.pen = CW'(ra);
			m.nx = (FB+2)'(NORM_ONE);
			return;
		end
		c = '0;
		for (int b = CW - 1; b >= 0; b--) begin
			t = c | (64'd1 << b);
			if (t * t <= s)
				c = t;
		end
		m.pen = CW'(rs - c);
		qx = (magnitude(dx) << FB) / c;
		qy = (magnitude(dy) << FB) / c;
		m.nx = (FB+2)'(dx < 0 ? -qx : qx);
		m.ny = (FB+2)'(dy < 0 ? -qy : qy);
	endfunction

	function automatic manifold_t predict_manifold(pair_t p);
		manifold_t m;
		longint ax, ay, bx, by;
		m = '{1'b0, '0, '0, '0, 1'b0};
		ax = longint'(p.ax);
		ay = longint'(p.ay);
		bx = longint'(p.bx);
		by = longint'(p.by);
		m.swapped = (p.op == cm2_pkg::OP_BOX_CIRCLE);
		case (p.op)
			cm2_pkg::OP_BOX_BOX: box_overlap(bx - ax, by - ay, longint'(p.aw),
				longint'(p.ah), longint'(p.bw), longint'(p.bh), m);
			cm2_pkg::OP_CIRCLE_CIRCLE: circle_overlap(bx - ax, by - ay,
				longint'(p.ar), longint'(p.br), m);
			cm2_pkg::OP_CIRCLE_BOX: box_overlap(bx - ax, by - ay, 2 * longint'(p.ar),
				2 * longint'(p.ar), longint'(p.bw), longint'(p.bh), m);
			default: box_overlap(ax - bx, ay - by, 2 * longint'(p.br),
				2 * longint'(p.br), longint'(p.aw), longint'(p.ah), m);
		endcase
		return m;
	endfunction

	function automatic pair_t mk_pair(cm2_pkg::op_t op, longint ax, longint ay,
			longint aw, longint ah, longint ar, longint bx, longint by, longint bw,
			longint bh, longint br);
		pair_t p;
		p.op = op;
		p.ax = CW'(ax);
		p.ay = CW'(ay);
		p.aw = (CW-1)'(aw);
		p.ah = (CW-1)'(ah);
		p.ar = (CW-2)'(ar);
		p.bx = CW'(bx);
		p.by = CW'(by);
		p.bw = (CW-1)'(bw);
		p.bh = (CW-1)'(bh);
		p.br = (CW-2)'(br);
		return p;
	endfunction

	task automatic send_pair(pair_t p, int gap, bit typed, manifold_t want);
		while ($urandom_range(99) < gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= p.op;
		a_x <= p.ax;
		a_y <= p.ay;
		a_width <= p.aw;
		a_height <= p.ah;
		a_radius <= p.ar;
		b_x <= p.bx;
		b_y <= p.by;
		b_width <= p.bw;
		b_height <= p.bh;
		b_radius <= p.br;
		do
			@(posedge clk);
		while (busy);
		pending_manifolds.push_back(typed ? want : predict_manifold(p));
	endtask

	always @(posedge clk) begin
		manifold_t e;
		if (arst_n && done) begin
			if (pending_manifolds.size() == 0) begin
				$error("result arrived with no item outstanding");
				fail_count++;
			end else begin
				e = pending_manifolds.pop_front();
				if (hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, hit);
					fail_count++;
				end
				if (penetration !== e.pen) begin
					$error("penetration: expected %0d, got %0d", e.pen, penetration);
					fail_count++;
				end
				if (normal_x !== e.nx) begin
					$error("normal_x: expected %0d, got %0d", $signed(e.nx), normal_x);
					fail_count++;
				end
				if (normal_y !== e.ny) begin
					$error("normal_y: expected %0d, got %0d", $signed(e.ny), normal_y);
					fail_count++;
				end
				if (order_swapped !== e.swapped) begin
					$error("order_swapped: expected %0d, got %0d", e.swapped,
						order_swapped);
					fail_count++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		manifold_t none, none_sw;
		pair_t p;
		longint span, ox, oy;
		int gaps[5];
		int waited;
		gaps = '{0, 87, 0, 15, 0};
		none = '{1'b0, '0, '0, '0, 1'b0};
		none_sw = '{1'b0, '0, '0, '0, 1'b1};
		start <= 1'b0;
		operation <= cm2_pkg::OP_BOX_BOX;
		{a_x, a_y, b_x, b_y} <= '0;
		{a_width, a_height, b_width, b_height} <= '0;
		{a_radius, b_radius} <= '0;
		arst_n = 1'b0;

		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_BOX, 0, 0, 4 << 16, 2 << 16, 0, 0, 0,
			4 << 16, 2 << 16, 0), 1, '{1'b1, 32'd262144, 18'd65536, 18'd0, 1'b0}});
		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_BOX, 0, 0, 1 << 16, 1 << 16, 0,
			1000 << 16, 0, 1 << 16, 1 << 16, 0), 1, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_BOX, -2147483648, 0, 2147483647,
			2147483647, 0, 2147483647, 0, 2147483647, 2147483647, 0), 1, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_BOX, 5, 5, 2147483647, 2147483647, 0,
			5, 5, 2147483647, 2147483647, 0), 1,
			'{1'b1, 32'd2147483647, 18'd0, 18'd65536, 1'b0}});
		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			none});
		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_BOX, 3 << 16, 1 << 16, 4 << 16,
			6 << 16, 0, 0, -(1 << 16), 4 << 16, 6 << 16, 0), 0, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_BOX, 0, 0, 4 << 16, 4 << 16, 0,
			1 << 16, 1 << 16, 4 << 16, 4 << 16, 0), 0, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_CIRCLE_CIRCLE, 7, 9, 0, 0, 5 << 16, 7, 9,
			0, 0, 3 << 16), 1, '{1'b1, 32'd327680, 18'd65536, 18'd0, 1'b0}});
		rows.push_back('{mk_pair(cm2_pkg::OP_CIRCLE_CIRCLE, -2147483648, 2147483647,
			0, 0, 1073741823, -2147483648, 2147483647, 0, 0, 1073741823), 1,
			'{1'b1, 32'd1073741823, 18'd65536, 18'd0, 1'b0}});
		rows.push_back('{mk_pair(cm2_pkg::OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 5 << 16,
			8 << 16, 0, 0, 0, 3 << 16), 1, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			0), 1, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 5 << 16,
			3 << 16, 4 << 16, 0, 0, 3 << 16), 0, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_CIRCLE_CIRCLE, 2 << 16, 1 << 16, 0, 0,
			4 << 16, -(1 << 16), -(3 << 16), 0, 0, 2 << 16), 0, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 1073741823,
			12345, -777777, 0, 0, 1073741823), 0, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_CIRCLE_BOX, 0, 0, 0, 0, 2 << 16, 3 << 16,
			1 << 16, 4 << 16, 2 << 16, 0), 0, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_CIRCLE_BOX, 0, 0, 0, 0, 1 << 16,
			50 << 16, 0, 4 << 16, 2 << 16, 0), 1, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_CIRCLE, 0, 0, 4 << 16, 2 << 16, 0,
			-(2 << 16), 1 << 16, 0, 0, 2 << 16), 0, none});
		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_CIRCLE, 0, 0, 4 << 16, 2 << 16, 0, 0,
			-(90 << 16), 0, 0, 2 << 16), 1, none_sw});
		rows.push_back('{mk_pair(cm2_pkg::OP_BOX_CIRCLE, 0, 0, 2147483647, 2147483647,
			0, 0, 0, 0, 0, 1073741823), 0, none});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_pair(rows[i].pair, 0, rows[i].typed, rows[i].want);

		foreach (gaps[g]) begin
			for (int n = 0; n < 150; n++) begin
				p.op = cm2_pkg::op_t'($urandom_range(3));
				p.ax = $urandom;
				p.ay = $urandom;
				p.aw = (CW-1)'($urandom >> $urandom_range(1, 31));
				p.ah = (CW-1)'($urandom >> $urandom_range(1, 31));
				p.ar = (CW-2)'($urandom >> $urandom_range(2, 31));
				p.bw = (CW-1)'($urandom >> $urandom_range(1, 31));
				p.bh = (CW-1)'($urandom >> $urandom_range(1, 31));
				p.br = (CW-2)'($urandom >> $urandom_range(2, 31));
				if ($urandom_range(9) < 7) begin
					span = longint'($urandom >> $urandom_range(1, 31));
					ox = longint'($urandom) % (2 * span + 1) - span;
					oy = longint'($urandom) % (2 * span + 1) - span;
					p.bx = CW'(longint'(p.ax) + ox);
					p.by = CW'(longint'(p.ay) + oy);
				end else begin
					p.bx = $urandom;
					p.by = $urandom;
				end
				send_pair(p, gaps[g], 0, none);
			end
			start <= 1'b0;
			while (pending_manifolds.size() != 0)
				@(posedge clk);
		end

		waited = 0;
		while (pending_manifolds.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending_manifolds.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/cm2_pkg.sv
sv/cm2_front.sv
sv/cm2_queue.sv
sv/cm2_back.sv
sv/collision_manifold_2d_top.sv
tb/tb_collision_manifold_2d_top.sv
